FILE: rtl/core/stc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stc_pkg
// Shared kinds, widths and stage records of the scalar type converter.
// ----------------------------------------------------------------------------
package stc_pkg;

    localparam logic [3:0] K_BOOL = 4'd0;
    localparam logic [3:0] K_CHAR = 4'd1;
    localparam logic [3:0] K_I8   = 4'd2;
    localparam logic [3:0] K_I64  = 4'd5;
    localparam logic [3:0] K_U8   = 4'd6;
    localparam logic [3:0] K_U64  = 4'd9;
    localparam logic [3:0] K_F32  = 4'd10;
    localparam logic [3:0] K_F64  = 4'd11;

    localparam logic [1:0] E_OK    = 2'd0;
    localparam logic [1:0] E_RANGE = 2'd1;
    localparam logic [1:0] E_OVF   = 2'd2;

    // operation classes decided in the first stage
    localparam logic [2:0] OP_ZERO = 3'd0;
    localparam logic [2:0] OP_INT  = 3'd1;
    localparam logic [2:0] OP_I2F  = 3'd2;
    localparam logic [2:0] OP_F2I  = 3'd3;
    localparam logic [2:0] OP_F2F  = 3'd4;
    localparam logic [2:0] OP_PASS = 3'd5;

    // unpacked operand: value = (-1)^sgn * mag * 2^(exp - 63); mag is normalized in the second stage
    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  tk;
        logic        sgn;
        logic        zero;
        logic        inf;
        logic        nan;
        logic [63:0] mag;
        logic signed [12:0] exp;
        logic [63:0] raw;
    } t_unp;

    typedef struct packed {
        logic [63:0] res;
        logic [1:0]  err;
    } t_res;

    function automatic logic [6:0] kind_width(input logic [3:0] k);
        logic [6:0] w;
        w = 7'd64;
        if (k == K_BOOL) w = 7'd1;
        else if (k == K_CHAR) w = 7'd8;
        else if (k >= K_I8 && k <= K_I64) w = 7'd8 << (k - K_I8);
        else if (k >= K_U8 && k <= K_U64) w = 7'd8 << (k - K_U8);
        return w;
    endfunction

    function automatic logic kind_signed(input logic [3:0] k);
        return (k >= K_CHAR && k <= K_I64);
    endfunction

    function automatic logic [63:0] fit_int(input logic [63:0] v, input logic [3:0] k);
        logic [6:0]  w;
        logic [63:0] m;
        logic [63:0] r;
        w = kind_width(k);
        m = (w >= 7'd64) ? '1 : ((64'd1 << w[5:0]) - 64'd1);
        r = v & m;
        if (k == K_BOOL) r = {63'd0, |v};
        else if (w < 7'd64 && kind_signed(k) && r[w[5:0] - 6'd1]) r = r | ~m;
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/stc_unpack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stc_unpack
// Stage 1: classify the conversion and unpack the operand to sign, magnitude
// and exponent.
// ----------------------------------------------------------------------------
module stc_unpack (
    input  wire logic [3:0]  i_sk,
    input  wire logic [3:0]  i_tk,
    input  wire logic [63:0] i_bits,
    output stc_pkg::t_unp    o_unp
);
    import stc_pkg::*;

    logic [63:0] v;
    logic        s_f32;
    logic        s_f64;
    logic        t_flt;
    logic [10:0] e64;
    logic [7:0]  e32;

    always_comb begin
        s_f32 = (i_sk == K_F32);
        s_f64 = (i_sk == K_F64);
        t_flt = (i_tk == K_F32) || (i_tk == K_F64);
        v     = (i_sk == K_BOOL) ? {63'd0, i_bits[0]} : fit_int(i_bits, i_sk);
        e64   = i_bits[62:52];
        e32   = i_bits[30:23];
        o_unp = '0;
        o_unp.tk  = i_tk;
        o_unp.raw = i_bits;
        if (i_sk > K_F64 || i_tk > K_F64) begin
            o_unp.op = OP_ZERO;
        end else if (s_f32 || s_f64) begin
            if (i_tk == i_sk) begin
                o_unp.op  = OP_PASS;
                o_unp.raw = s_f32 ? {32'd0, i_bits[31:0]} : i_bits;
            end else if (t_flt) begin
                o_unp.op = OP_F2F;
            end else if (i_tk == K_BOOL) begin
                o_unp.op  = OP_PASS;
                o_unp.raw = {63'd0, s_f32 ? |i_bits[30:0] : |i_bits[62:0]};
            end else begin
                o_unp.op = OP_F2I;
            end
            if (s_f32) begin
                o_unp.sgn = i_bits[31];
                o_unp.inf = (e32 == 8'hff) && (i_bits[22:0] == '0);
                o_unp.nan = (e32 == 8'hff) && (i_bits[22:0] != '0);
                o_unp.zero = (i_bits[30:0] == '0);
                o_unp.mag = {(e32 != '0), i_bits[22:0], 40'd0};
                o_unp.exp = (e32 == '0) ? 13'sd63 - 13'sd126 - 13'sd63 + 13'sd63 - 13'sd63
                          : $signed({5'd0, e32}) - 13'sd127;
            end else begin
                o_unp.sgn = i_bits[63];
                o_unp.inf = (e64 == 11'h7ff) && (i_bits[51:0] == '0);
                o_unp.nan = (e64 == 11'h7ff) && (i_bits[51:0] != '0);
                o_unp.zero = (i_bits[62:0] == '0);
                o_unp.mag = {(e64 != '0), i_bits[51:0], 11'd0};
                o_unp.exp = (e64 == '0) ? -13'sd1022
                          : $signed({2'd0, e64}) - 13'sd1023;
            end
            if (s_f32 && e32 == '0) o_unp.exp = -13'sd126;
        end else if (t_flt) begin
            o_unp.op   = OP_I2F;
            o_unp.sgn  = kind_signed(i_sk) && v[63];
            o_unp.mag  = o_unp.sgn ? (~v + 64'd1) : v;
            o_unp.zero = (v == '0);
            o_unp.exp  = 13'sd63;
        end else begin
            o_unp.op  = OP_INT;
            o_unp.raw = fit_int(v, i_tk);
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/stc_norm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stc_norm
// Stage 2: normalize the magnitude so that bit 63 is set; adjust exponent.
// ----------------------------------------------------------------------------
module stc_norm (
    input  wire stc_pkg::t_unp i_unp,
    output stc_pkg::t_unp      o_unp
);
    import stc_pkg::*;

    logic [5:0] lz;

    always_comb begin
        lz = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (i_unp.mag[i]) lz = 6'(63 - i);
        end
        o_unp     = i_unp;
        o_unp.mag = i_unp.mag << lz;
        o_unp.exp = i_unp.exp - $signed({7'd0, lz});
    end
endmodule
`default_nettype wire

FILE: rtl/core/stc_pack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stc_pack
// Stage 3: round and pack to float, truncate and range check to integer, or pass the stage 1 result through.
// ----------------------------------------------------------------------------
module stc_pack (
    input  wire stc_pkg::t_unp i_unp,
    output stc_pkg::t_res      o_res
);
    import stc_pkg::*;

    logic        to32;
    logic [5:0]  mw;
    logic signed [12:0] emin;
    logic signed [12:0] bias;
    logic signed [12:0] sh;
    logic [127:0] ext;
    logic [63:0] kept;
    logic        rb;
    logic        st;
    logic [63:0] rnd;
    logic [6:0]  w;
    logic [63:0] ip;
    logic [63:0] iv;
    logic        ok;
    logic signed [12:0] eb;
    logic        ovf;

    always_comb begin
        o_res = '0;
        to32  = (i_unp.tk == K_F32);
        mw    = to32 ? 6'd23 : 6'd52;
        emin  = to32 ? -13'sd126 : -13'sd1022;
        bias  = to32 ? 13'sd127 : 13'sd1023;
        // significand bits kept: shift right by 63-mw plus denormal extra
        sh = 13'sd63 - $signed({7'd0, mw});
        if (i_unp.exp < emin) sh = sh + (emin - i_unp.exp);
        if (sh > 13'sd65) sh = 13'sd65;
        ext  = {i_unp.mag, 64'd0} >> sh[6:0];
        kept = ext[127:64];
        rb   = ext[63];
        st   = |ext[62:0];
        rnd  = kept + {63'd0, rb && (st || kept[0])};
        eb   = (i_unp.exp < emin) ? 13'sd0 : i_unp.exp + bias;
        if (rnd[mw + 6'd1]) begin
            rnd = rnd >> 1;
            eb  = eb + 13'sd1;
        end else if (i_unp.exp < emin && rnd[mw]) begin
            eb = 13'sd1;
        end
        // flag any magnitude above the binary32 maximum before rounding
        ovf = i_unp.inf ||
              (to32 && !i_unp.zero &&
               (i_unp.exp > 13'sd127 ||
                (i_unp.exp == 13'sd127 && (&i_unp.mag[63:40]) && (|i_unp.mag[39:0]))));
        // integer path
        w  = kind_width(i_unp.tk);
        ip = '0;
        if (i_unp.exp >= 13'sd0 && i_unp.exp <= 13'sd63) begin
            ip = i_unp.mag >> (6'd63 - i_unp.exp[5:0]);
        end
        if (kind_signed(i_unp.tk)) begin
            ok = !i_unp.nan && !i_unp.inf &&
                 (i_unp.zero || i_unp.exp < $signed({6'd0, w}) - 13'sd1 ||
                  (i_unp.sgn && i_unp.exp == $signed({6'd0, w}) - 13'sd1 &&
                   ip == (64'd1 << (w[5:0] - 6'd1))));
        end else begin
            ok = !i_unp.nan && !i_unp.inf &&
                 (i_unp.zero || i_unp.exp < 13'sd0 ||
                  (!i_unp.sgn && i_unp.exp < $signed({6'd0, w})));
        end
        iv = i_unp.sgn ? (~ip + 64'd1) : ip;
        unique case (i_unp.op)
            OP_ZERO: o_res = '0;
            OP_INT, OP_PASS: o_res.res = i_unp.raw;
            OP_F2I: begin
                if (ok) o_res.res = fit_int(iv, i_unp.tk);
                else o_res.err = E_RANGE;
            end
            OP_I2F, OP_F2F: begin
                if (i_unp.nan) begin
                    if (to32) o_res.res = {32'd0, i_unp.raw[63], 8'hff, 1'b1, i_unp.raw[50:29]};
                    else o_res.res = {i_unp.raw[31], 12'hfff, i_unp.raw[21:0], 29'd0};
                end else if (to32 && ovf) begin
                    o_res.err = E_OVF;
                end else if (i_unp.inf) begin
                    o_res.res = {i_unp.sgn, 11'h7ff, 52'd0};
                end else if (i_unp.zero) begin
                    o_res.res = to32 ? {32'd0, i_unp.sgn, 31'd0} : {i_unp.sgn, 63'd0};
                end else if (to32) begin
                    o_res.res = {32'd0, i_unp.sgn, eb[7:0], rnd[22:0]};
                end else begin
                    o_res.res = {i_unp.sgn, eb[10:0], rnd[51:0]};
                end
            end
            default: o_res = '0;
        endcase
    end
endmodule
`default_nettype wire

FILE: rtl/core/scalar_type_converter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scalar_type_converter
// Converts one scalar between bool, char, integers, binary32 and binary64.
// ----------------------------------------------------------------------------
// Input item on s_axis: tdata = {source_bits, target_kind, source_kind}
// (source_kind in bits 3:0). Result on m_axis: tdata = {error_code,
// result_bits} padded to 72 bits (result_bits in bits 63:0).
// Three register stages: unpack, normalize, round/pack. An accepted item
// passes through the unpack and normalize registers into the output
// register, whose valid bit drives tvalid; one item per cycle is sustained
// while the receiver takes every result.
// Each stage holds while the next is full and stalled, so a stalled
// receiver backs up the pipe without losing items; tready falls only when
// all three stages are full and the output is not taken.
// Synchronous reset empties every stage.
// ----------------------------------------------------------------------------
module scalar_type_converter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // source_kind, target_kind, source_bits
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata   // result_bits, error_code
);
    import stc_pkg::*;

    t_unp r_s1, n_s1, r_s2, n_s2;
    t_res r_s3, n_s3;
    logic r_v1, r_v2, r_v3;
    logic adv1, adv2, adv3;

    stc_unpack u_unp (
        .i_sk(s_axis_tdata[3:0]), .i_tk(s_axis_tdata[7:4]),
        .i_bits(s_axis_tdata[71:8]), .o_unp(n_s1)
    );
    stc_norm u_norm (.i_unp(r_s1), .o_unp(n_s2));
    stc_pack u_pack (.i_unp(r_s2), .o_res(n_s3));

    assign adv3 = !r_v3 || m_axis_tready;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;
    assign s_axis_tready = adv1;
    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = {6'd0, r_s3.err, r_s3.res};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= s_axis_tvalid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) r_s1 <= n_s1;
        if (adv2) r_s2 <= n_s2;
        if (adv3) r_s3 <= n_s3;
    end
endmodule
`default_nettype wire

FILE: verif/tb_scalar_type_converter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_scalar_type_converter
// Self-checking bench for the scalar type converter. A queue of conversion
// requests (directed corner cases, then random kinds and values) feeds a
// bursty driver, a stalling sink takes the results, and each accepted result
// is checked against a bit-level conversion model kept in the bench.
// ----------------------------------------------------------------------------
module tb_scalar_type_converter;
    import stc_pkg::*;

    localparam int WATCHDOG_CYCLES = 4000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // source_kind, target_kind, source_bits
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;   // result_bits, error_code

    typedef struct packed {
        logic [63:0] res;
        logic [1:0]  err;
    } conv_t;

    logic [71:0] pending_items[$];
    conv_t       expected_conv[$];
    int          burst_left;
    int          gap_left;
    int          stall_left;
    int          flow_left;
    int          idle_cycles;
    int          fail_count;
    logic        in_taken;

    scalar_type_converter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    function automatic int width_of(input logic [3:0] k);
        if (k == K_BOOL) return 1;
        if (k == K_CHAR) return 8;
        if (k >= K_I8 && k <= K_I64) return 8 << (k - K_I8);
        if (k >= K_U8 && k <= K_U64) return 8 << (k - K_U8);
        return 64;
    endfunction

    function automatic logic is_signed_kind(input logic [3:0] k);
        return k >= K_CHAR && k <= K_I64;
    endfunction

    function automatic logic [63:0] narrow_int(input logic [63:0] v, input logic [3:0] k);
        int          w;
        logic [63:0] m;
        logic [63:0] r;
        if (k == K_BOOL) return {63'd0, |v};
        w = width_of(k);
        if (w == 64) return v;
        m = (64'd1 << w) - 64'd1;
        r = v & m;
        if (is_signed_kind(k) && r[w-1]) r = r | ~m;
        return r;
    endfunction

    function automatic logic [63:0] int_to_float(input logic [63:0] v, input logic sgn,
                                                 input logic dbl);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] keep;
        logic [63:0] rem;
        logic [63:0] half;
        int          p;
        int          mb;
        int          sh;
        neg = sgn && v[63];
        mag = neg ? -v : v;
        if (mag == 64'd0) return 64'd0;
        p = 0;
        for (int i = 0; i < 64; i++) if (mag[i]) p = i;
        mb = dbl ? 52 : 23;
        if (p <= mb) begin
            keep = mag << (mb - p);
        end else begin
            sh = p - mb;
            keep = mag >> sh;
            rem = mag & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && keep[0])) keep = keep + 64'd1;
            if ((keep >> (mb + 1)) != 64'd0) begin
                keep = keep >> 1;
                p = p + 1;
            end
        end
        if (dbl) return {neg, 11'(p + 1023), keep[51:0]};
        return {32'd0, neg, 8'(p + 127), keep[22:0]};
    endfunction

    function automatic logic [63:0] widen_f32(input logic [31:0] b);
        logic [23:0] sig;
        int          e;
        if (b[30:23] == 8'hff) begin
            if (b[22:0] == 23'd0) return {b[31], 11'h7ff, 52'd0};
            return {b[31], 12'hfff, b[21:0], 29'd0};
        end
        if (b[30:23] == 8'd0) begin
            if (b[22:0] == 23'd0) return {b[31], 63'd0};
            e = -126;
            sig = {1'b0, b[22:0]};
            while (!sig[23]) begin
                sig = sig << 1;
                e = e - 1;
            end
            return {b[31], 11'(e + 1023), sig[22:0], 29'd0};
        end
        return {b[31], 11'(int'(b[30:23]) - 127 + 1023), b[22:0], 29'd0};
    endfunction

    function automatic conv_t narrow_f64(input logic [63:0] b);
        conv_t       c;
        logic [52:0] sig;
        logic [63:0] keep;
        logic [63:0] rem;
        logic [63:0] half;
        int          e;
        int          sh;
        c.err = E_OK;
        c.res = 64'd0;
        if (b[62:52] == 11'h7ff && b[51:0] != 52'd0) begin
            c.res = {32'd0, b[63], 9'h1ff, b[50:29]};
            return c;
        end
        if (b[62:52] == 11'd0) begin
            c.res = {32'd0, b[63], 31'd0};
            return c;
        end
        e = int'(b[62:52]) - 1023;
        if (e > 127 || (e == 127 && b[51:0] > {23'h7fffff, 29'd0})) begin
            c.err = E_OVF;
            return c;
        end
        sig = {1'b1, b[51:0]};
        sh = (e >= -126) ? 29 : -e - 97;
        if (sh >= 55) begin
            c.res = {32'd0, b[63], 31'd0};
            return c;
        end
        keep = 64'(sig) >> sh;
        rem = 64'(sig) & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && keep[0])) keep = keep + 64'd1;
        if (e >= -126) begin
            if (keep[24]) begin
                keep = keep >> 1;
                e = e + 1;
            end
            c.res = {32'd0, b[63], 8'(e + 127), keep[22:0]};
        end else begin
            c.res = {32'd0, b[63], keep[30:0]};
        end
        return c;
    endfunction

    function automatic conv_t float_to_int(input logic [63:0] b, input logic [3:0] t);
        conv_t       c;
        logic [52:0] sig;
        logic [63:0] mag;
        logic        neg;
        logic        ok;
        int          e;
        int          w;
        c.err = E_OK;
        c.res = 64'd0;
        neg = b[63];
        w = width_of(t);
        mag = 64'd0;
        if (b[62:52] == 11'h7ff) begin
            c.err = E_RANGE;
            return c;
        end
        if (b[62:52] != 11'd0) begin
            e = int'(b[62:52]) - 1023;
            sig = {1'b1, b[51:0]};
            if (e > 63) begin
                c.err = E_RANGE;
                return c;
            end
            if (e >= 52) mag = 64'(sig) << (e - 52);
            else if (e >= 0) mag = 64'(sig) >> (52 - e);
        end
        if (is_signed_kind(t))
            ok = neg ? ({1'b0, mag} <= (65'd1 << (w - 1))) : ({1'b0, mag} < (65'd1 << (w - 1)));
        else
            ok = neg ? (mag == 64'd0) : ({1'b0, mag} < (65'd1 << w));
        if (!ok) c.err = E_RANGE;
        else c.res = narrow_int(neg ? -mag : mag, t);
        return c;
    endfunction

    function automatic conv_t convert_scalar(input logic [71:0] item);
        conv_t       c;
        logic [3:0]  s;
        logic [3:0]  t;
        logic [63:0] b;
        logic [63:0] v;
        s = item[3:0];
        t = item[7:4];
        b = item[71:8];
        c.res = 64'd0;
        c.err = E_OK;
        if (s > K_F64 || t > K_F64) return c;
        if (s == K_F32) begin
            if (t == K_F32) c.res = {32'd0, b[31:0]};
            else if (t == K_F64) c.res = widen_f32(b[31:0]);
            else if (t == K_BOOL) c.res = {63'd0, |b[30:0]};
            else c = float_to_int(widen_f32(b[31:0]), t);
        end else if (s == K_F64) begin
            if (t == K_F64) c.res = b;
            else if (t == K_F32) c = narrow_f64(b);
            else if (t == K_BOOL) c.res = {63'd0, |b[62:0]};
            else c = float_to_int(b, t);
        end else begin
            v = (s == K_BOOL) ? {63'd0, b[0]} : narrow_int(b, s);
            if (t == K_F32) c.res = int_to_float(v, is_signed_kind(s), 1'b0);
            else if (t == K_F64) c.res = int_to_float(v, is_signed_kind(s), 1'b1);
            else c.res = narrow_int(v, t);
        end
        return c;
    endfunction

    function automatic logic [63:0] random_operand(input logic [3:0] s);
        logic [63:0] r;
        logic        sg;
        int          pick;
        r = {$urandom, $urandom};
        sg = $urandom_range(0, 1);
        pick = $urandom_range(0, 9);
        if (s == K_F32) begin
            case (pick)
                0: r = {32'd0, sg, 8'hff, (r[0] ? 23'd0 : r[22:0])};
                1: r = {32'd0, sg, 8'd0, (r[0] ? 23'd0 : r[22:0])};
                2, 3: r = {32'd0, sg, 8'($urandom_range(110, 127)), r[22:0]};
                4, 5, 6: r = {32'd0, sg, 8'($urandom_range(127, 191)),
                              (r[40] ? 23'd0 : r[22:0])};
                7: r = {32'd0, r[31:0]};
                default: ;
            endcase
        end else if (s == K_F64) begin
            case (pick)
                0: r = {sg, 11'h7ff, (r[60] ? 52'd0 : r[51:0])};
                1: r = {sg, 11'd0, r[51:0]};
                2: r = {sg, 11'($urandom_range(1023 - 155, 1023 - 120)), r[51:0]};
                3: r = {sg, 11'($urandom_range(1023 + 125, 1023 + 129)),
                        (r[60] ? {23'h7fffff, 29'd0} + 52'($urandom_range(0, 2)) - 52'd1
                               : r[51:0])};
                4, 5, 6: r = {sg, 11'($urandom_range(1010, 1023 + 66)),
                              (r[61] ? {r[51:40], 40'd0} : r[51:0])};
                7: r = {sg, 11'($urandom_range(1023 - 30, 1023)), r[51:0]};
                default: ;
            endcase
        end else begin
            case (pick)
                0: r = 64'($urandom_range(0, 3)) - 64'd2;
                1: r = r >> $urandom_range(0, 63);
                2: r = {sg, 63'd0} | ((64'd1 << $urandom_range(0, 63)) - (r[0] ? 64'd1 : 64'd0));
                default: ;
            endcase
        end
        return r;
    endfunction

    function automatic logic [3:0] random_kind();
        if ($urandom_range(0, 19) == 0) return 4'($urandom_range(12, 15));
        return 4'($urandom_range(0, 11));
    endfunction

    task automatic queue_item(input logic [3:0] s, input logic [3:0] t, input logic [63:0] b);
        pending_items.push_back({b, t, s});
    endtask

    // driver: bursts with random gaps, hold while not taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (burst_left == 0 && gap_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
            if (gap_left > 0 && burst_left == 0) begin
                gap_left = gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                burst_left = burst_left - 1;
                s_axis_tdata <= pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // sink: alternating flow and stall stretches
    always @(negedge i_clk) begin
        if (flow_left > 0) begin
            flow_left = flow_left - 1;
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_axis_tready <= ($urandom_range(0, 3) == 0);
        end else begin
            flow_left = $urandom_range(0, 50);
            stall_left = $urandom_range(0, 12);
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        conv_t got;
        conv_t want;
        logic  seen;
        seen = 1'b0;
        in_taken <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_conv.push_back(convert_scalar(s_axis_tdata));
                seen = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                seen = 1'b1;
                got.res = m_axis_tdata[63:0];
                got.err = m_axis_tdata[65:64];
                if (expected_conv.size() == 0) begin
                    $display("%0t: unexpected result res=%h err=%0d", $time, got.res, got.err);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_conv.pop_front();
                    if (got.res !== want.res || got.err !== want.err) begin
                        $display("%0t: mismatch expected res=%h err=%0d, actual res=%h err=%0d",
                                 $time, want.res, want.err, got.res, got.err);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            idle_cycles <= seen ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("[scalar_type_converter] ERROR");
                $finish;
            end
        end
    end

    initial begin
        logic [3:0] s;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        burst_left = 0;
        gap_left = 0;
        stall_left = 0;
        flow_left = 0;
        idle_cycles = 0;
        fail_count = 0;
        in_taken = 1'b0;

        queue_item(K_I64, K_U8, 64'h8000_0000_0000_00ff);
        queue_item(K_BOOL, K_I64, 64'hffff_ffff_ffff_fffe);
        queue_item(K_CHAR, K_U64, 64'h0000_0000_0000_0080);
        queue_item(K_U64, K_F32, 64'hffff_ffff_ffff_ffff);
        queue_item(K_I64, K_F64, 64'h8000_0000_0000_0000);
        queue_item(K_U64, K_F64, 64'h0020_0000_0000_0001);
        queue_item(K_U8, K_BOOL, 64'h0000_0000_0000_0100);
        queue_item(K_F32, K_F64, 64'h0000_0000_7fa0_0001);
        queue_item(K_F32, K_BOOL, 64'h0000_0000_8000_0000);
        queue_item(K_F32, K_CHAR, 64'h0000_0000_c300_0000);
        queue_item(K_F32, K_CHAR, 64'h0000_0000_4300_0000);
        queue_item(K_F32, K_I64 - 4'd1, 64'h0000_0000_4f00_0000);
        queue_item(K_F32, K_U8, 64'h0000_0000_bf66_6666);
        queue_item(K_F32, K_F32, 64'hdead_beef_0000_0001);
        queue_item(K_F64, K_F32, 64'h7ff0_0000_0000_0000);
        queue_item(K_F64, K_F32, 64'h47ef_ffff_f000_0000);
        queue_item(K_F64, K_F32, 64'h47ef_ffff_e000_0000);
        queue_item(K_F64, K_F32, 64'hfff8_0000_2000_0001);
        queue_item(K_F64, K_F32, 64'h3690_0000_0000_0001);
        queue_item(K_F64, K_U64, 64'h43ef_ffff_ffff_ffff);
        queue_item(K_F64, K_I64, 64'hc3e0_0000_0000_0000);
        queue_item(K_F64, K_BOOL, 64'h7ff8_0000_0000_0000);
        queue_item(K_F64, K_U64, 64'h43f0_0000_0000_0000);
        queue_item(4'd12, K_F64, 64'hffff_ffff_ffff_ffff);
        queue_item(K_F64, 4'd15, 64'h3ff0_0000_0000_0000);
        for (int n = 0; n < 1450; n++) begin
            s = random_kind();
            queue_item(s, random_kind(), random_operand(s));
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_items.size() == 0 && !s_axis_tvalid && expected_conv.size() == 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && expected_conv.size() == 0) begin
            $display("[scalar_type_converter] OK");
        end else begin
            $display("[scalar_type_converter] ERROR");
        end
        $finish;
    end

endmodule
